/* rtl/fsti_pkg.sv */
// Shared types, widths and helper functions for the impedance tensor block.
`default_nettype none
package fsti_pkg;

  // Width of the quotient each lane produces before rounding.
  localparam int QW = 33;
  // Width of the squared determinant magnitude.
  localparam int MW = 66;
  // Width of a lane's partial remainder.
  localparam int RW = MW + 1;
  // Number of real or imaginary result parts: four elements, two parts each.
  localparam int NLANE = 8;

  typedef struct packed {
    logic [31:0] ex_pol1;
    logic [31:0] ex_pol2;
    logic [31:0] ey_pol1;
    logic [31:0] ey_pol2;
    logic [31:0] hx_pol1;
    logic [31:0] hx_pol2;
    logic [31:0] hy_pol1;
    logic [31:0] hy_pol2;
  } in_item_t;

  typedef struct packed {
    logic [63:0] z_xx;
    logic [63:0] z_xy;
    logic [63:0] z_yx;
    logic [63:0] z_yy;
    logic        singular;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } c16_t;

  typedef struct packed {
    logic signed [33:0] re;
    logic signed [33:0] im;
  } c34_t;

  // One division lane: partial remainder, numerator bits still to shift in,
  // quotient bits so far, sign of the part and an early overflow mark.
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] numlo;
    logic [QW-1:0] quo;
    logic          neg;
    logic          presat;
  } lane_t;

  typedef struct packed {
    logic                vld;
    logic                singular;
    logic [MW-1:0]       m;
    lane_t [NLANE-1:0]   lane;
  } stage_t;

  function automatic c16_t unpack16(input logic [31:0] v);
    c16_t c;
    c.re = $signed(v[31:16]);
    c.im = $signed(v[15:0]);
    return c;
  endfunction

  // a*b - c*d on complex values, exact.
  function automatic c34_t cdp(input c16_t a, input c16_t b, input c16_t c, input c16_t d);
    c34_t r;
    r.re = a.re * b.re - a.im * b.im - c.re * d.re + c.im * d.im;
    r.im = a.re * b.im + a.im * b.re - c.re * d.im - c.im * d.re;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/fsti_front.sv */
// Front end: cross products, determinant, numerator parts and divider setup.
`default_nettype none
module fsti_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire fsti_pkg::in_item_t in_item,
  output fsti_pkg::stage_t       out_stage
);
  import fsti_pkg::*;

  c16_t ex1, ex2, ey1, ey2, hx1, hx2, hy1, hy2;
  c34_t d_nxt, d_r;
  c34_t [3:0] n_nxt, n_r;
  logic vld1_r, vld2_r, vld3_r;

  logic signed [67:0] p_ar, p_bi, p_ai, p_br;
  logic signed [67:0] dd_re, dd_im;
  logic [MW-1:0] m_nxt, m2_r;
  logic [NLANE-1:0] [RW-1:0] part_nxt;
  logic [NLANE-1:0] [RW-1:0] part_r;
  logic sing_nxt, sing2_r;
  stage_t stg_nxt, stg_r;
  logic [MW-1:0] mag;

  assign ex1 = unpack16(in_item.ex_pol1);
  assign ex2 = unpack16(in_item.ex_pol2);
  assign ey1 = unpack16(in_item.ey_pol1);
  assign ey2 = unpack16(in_item.ey_pol2);
  assign hx1 = unpack16(in_item.hx_pol1);
  assign hx2 = unpack16(in_item.hx_pol2);
  assign hy1 = unpack16(in_item.hy_pol1);
  assign hy2 = unpack16(in_item.hy_pol2);

  assign d_nxt    = cdp(hx1, hy2, hy1, hx2);
  assign n_nxt[0] = cdp(ex1, hy2, hy1, ex2);
  assign n_nxt[1] = cdp(ex2, hx1, hx2, ex1);
  assign n_nxt[2] = cdp(ey1, hy2, hy1, ey2);
  assign n_nxt[3] = cdp(ey2, hx1, hx2, ey1);

  // Second stage: |D|^2 and N*conj(D) for every element.
  always_comb begin
    dd_re = d_r.re * d_r.re;
    dd_im = d_r.im * d_r.im;
    m_nxt = MW'(dd_re + dd_im);
    sing_nxt = (d_r.re == '0) && (d_r.im == '0);
    for (int k = 0; k < 4; k++) begin
      p_ar = n_r[k].re * d_r.re;
      p_bi = n_r[k].im * d_r.im;
      p_ai = n_r[k].im * d_r.re;
      p_br = n_r[k].re * d_r.im;
      part_nxt[2*k]   = RW'(p_ar + p_bi);
      part_nxt[2*k+1] = RW'(p_ai - p_br);
    end
  end

  // Third stage: sign and magnitude, overflow precheck, divider seed.
  always_comb begin
    stg_nxt.vld      = vld2_r;
    stg_nxt.singular = sing2_r;
    stg_nxt.m        = m2_r;
    for (int l = 0; l < NLANE; l++) begin
      stg_nxt.lane[l].neg = part_r[l][RW-1];
      mag = part_r[l][RW-1] ? MW'(-part_r[l]) : MW'(part_r[l]);
      stg_nxt.lane[l].presat = {17'b0, mag} >= {m2_r, 17'b0};
      stg_nxt.lane[l].rem    = {18'b0, mag[MW-1:17]};
      stg_nxt.lane[l].numlo  = {mag[16:0], 16'b0};
      stg_nxt.lane[l].quo    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= acc;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    n_r     <= n_nxt;
    m2_r    <= m_nxt;
    part_r  <= part_nxt;
    sing2_r <= sing_nxt;
    stg_r   <= stg_nxt;
  end

  always_comb begin
    out_stage     = stg_r;
    out_stage.vld = vld3_r;
  end

endmodule
`default_nettype wire

/* rtl/fsti_cell.sv */
// One divider cell: a single restoring quotient bit for every lane.
`default_nettype none
module fsti_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire fsti_pkg::stage_t in_stage,
  output fsti_pkg::stage_t      out_stage
);
  import fsti_pkg::*;

  stage_t stg_nxt, stg_r;
  logic   vld_r;
  logic [RW:0] trial;
  logic        ge;

  always_comb begin
    stg_nxt = in_stage;
    for (int l = 0; l < NLANE; l++) begin
      trial = {in_stage.lane[l].rem, in_stage.lane[l].numlo[QW-1]};
      ge    = trial >= {2'b0, in_stage.m};
      stg_nxt.lane[l].rem   = ge ? RW'(trial - {2'b0, in_stage.m}) : RW'(trial);
      stg_nxt.lane[l].numlo = {in_stage.lane[l].numlo[QW-2:0], 1'b0};
      stg_nxt.lane[l].quo   = {in_stage.lane[l].quo[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_stage.vld;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  always_comb begin
    out_stage     = stg_r;
    out_stage.vld = vld_r;
  end

endmodule
`default_nettype wire

/* rtl/fsti_back.sv */
// Back end: rounding, clipping, sign restore and result packing.
`default_nettype none
module fsti_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire fsti_pkg::stage_t in_stage,
  output logic                  out_valid,
  output fsti_pkg::out_item_t   out_res
);
  import fsti_pkg::*;

  logic [NLANE-1:0][31:0] part;
  logic [NLANE-1:0]       lsat;
  logic [QW:0]            q;
  logic [QW:0]            limit;
  logic [31:0]            mag;
  out_item_t              res_nxt, res_r;
  logic                   vld_r;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      q = {1'b0, in_stage.lane[l].quo} +
          (QW+1)'({in_stage.lane[l].rem, 1'b0} >= {1'b0, in_stage.m});
      limit = in_stage.lane[l].neg ? (QW+1)'(34'h0_8000_0000) : (QW+1)'(34'h0_7FFF_FFFF);
      lsat[l] = in_stage.lane[l].presat || (q > limit);
      mag = lsat[l] ? limit[31:0] : q[31:0];
      part[l] = in_stage.lane[l].neg ? -mag : mag;
    end
    if (in_stage.singular) begin
      res_nxt = '0;
      res_nxt.singular = 1'b1;
    end else begin
      res_nxt.z_xx      = {part[0], part[1]};
      res_nxt.z_xy      = {part[2], part[3]};
      res_nxt.z_yx      = {part[4], part[5]};
      res_nxt.z_yy      = {part[6], part[7]};
      res_nxt.singular  = 1'b0;
      res_nxt.saturated = |lsat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_stage.vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

/* rtl/field_spectra_to_impedance.sv */
// Top level of the magnetotelluric impedance tensor pipeline.
// Throughput: one transaction per clock cycle, set by the 33-cell divider chain.
// busy is always low; results are strobed by out_valid for one cycle each.
// Reset (rst_n low, synchronous) empties the pipeline; no result appears until
// new transactions arrive.
`default_nettype none
module field_spectra_to_impedance (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire fsti_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output fsti_pkg::out_item_t      out_res
);
  import fsti_pkg::*;

  // The stage chain: entry 0 comes from the front end, entry QW feeds the back end.
  stage_t chain [QW+1];
  logic   acc;

  // The pipeline never stalls, so the block can always take a transaction.
  assign busy = 1'b0;
  assign acc  = start && !busy;

  // The front end forms the determinant D, the numerators N and the products
  // N*conj(D) and |D|^2 over two stages, then seeds every lane of the divider.
  fsti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_item   (in_item),
    .out_stage (chain[0])
  );

  // Each cell resolves one quotient bit of all eight parts and hands the lane
  // state to its neighbor, so a new transaction enters every cycle.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    fsti_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_stage  (chain[i]),
      .out_stage (chain[i+1])
    );
  end

  // The back end rounds half away from zero, clips to Q16.16 and packs results.
  fsti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stage  (chain[QW]),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire

/* rtl/fsti_checker.sv */
// Port-level checker for the impedance tensor block and its bind.
`default_nettype none
module fsti_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire fsti_pkg::out_item_t out_res
);
  import fsti_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##37 out_valid)
    else $error("result missing after accepted transaction");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.singular) |->
      (out_res.z_xx == '0 && out_res.z_xy == '0 && out_res.z_yx == '0 &&
       out_res.z_yy == '0 && !out_res.saturated))
    else $error("singular result not zero");

endmodule

bind field_spectra_to_impedance fsti_checker u_fsti_checker (.*);
`default_nettype wire

/* bench/tb_field_spectra_to_impedance.sv */
// Self-checking bench for the impedance tensor block: directed and random spectra.
`timescale 1ns / 1ps
`default_nettype none

// Holds predicted tensors in order and compares strobed results against them.
class tensor_scoreboard;
  fsti_pkg::out_item_t pending_q[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function logic signed [33:0] cross_re(fsti_pkg::c16_t a, fsti_pkg::c16_t b,
                                              fsti_pkg::c16_t c, fsti_pkg::c16_t d);
    logic signed [33:0] r;
    r = 34'(a.re) * 34'(b.re) - 34'(a.im) * 34'(b.im)
        - 34'(c.re) * 34'(d.re) + 34'(c.im) * 34'(d.im);
    return r;
  endfunction

  static function logic signed [33:0] cross_im(fsti_pkg::c16_t a, fsti_pkg::c16_t b,
                                              fsti_pkg::c16_t c, fsti_pkg::c16_t d);
    logic signed [33:0] r;
    r = 34'(a.re) * 34'(b.im) + 34'(a.im) * 34'(b.re)
        - 34'(c.re) * 34'(d.im) - 34'(c.im) * 34'(d.re);
    return r;
  endfunction

  // Scales one part by 2^16 over |D|^2, rounds half away from zero, clips.
  static function logic [31:0] scale_part(logic signed [127:0] p, logic [127:0] mag2,
                                          ref logic sat);
    logic [127:0] a, q, r, lim;
    logic neg;
    neg = p < 0;
    a = neg ? -p : p;
    q = (a << 16) / mag2;
    r = (a << 16) % mag2;
    if ((r << 1) >= mag2) q = q + 1;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? 32'(-q) : q[31:0];
  endfunction

  static function logic [63:0] impedance(logic signed [33:0] nr, logic signed [33:0] ni,
                                         logic signed [33:0] dr, logic signed [33:0] di,
                                         logic [127:0] mag2, ref logic sat);
    logic signed [127:0] pr, pi;
    pr = 128'(nr) * 128'(dr) + 128'(ni) * 128'(di);
    pi = 128'(ni) * 128'(dr) - 128'(nr) * 128'(di);
    return {scale_part(pr, mag2, sat), scale_part(pi, mag2, sat)};
  endfunction

  function void note_spectra(fsti_pkg::in_item_t it);
    fsti_pkg::c16_t ex1, ex2, ey1, ey2, hx1, hx2, hy1, hy2;
    logic signed [33:0] dr, di;
    logic [127:0] mag2;
    logic sat;
    fsti_pkg::out_item_t e;
    ex1 = it.ex_pol1; ex2 = it.ex_pol2; ey1 = it.ey_pol1; ey2 = it.ey_pol2;
    hx1 = it.hx_pol1; hx2 = it.hx_pol2; hy1 = it.hy_pol1; hy2 = it.hy_pol2;
    e = '0;
    sat = 1'b0;
    dr = cross_re(hx1, hy2, hy1, hx2);
    di = cross_im(hx1, hy2, hy1, hx2);
    if (dr == 0 && di == 0) begin
      e.singular = 1'b1;
    end else begin
      mag2 = 128'(dr) * 128'(dr) + 128'(di) * 128'(di);
      e.z_xx = impedance(cross_re(ex1, hy2, hy1, ex2), cross_im(ex1, hy2, hy1, ex2),
                         dr, di, mag2, sat);
      e.z_xy = impedance(cross_re(ex2, hx1, hx2, ex1), cross_im(ex2, hx1, hx2, ex1),
                         dr, di, mag2, sat);
      e.z_yx = impedance(cross_re(ey1, hy2, hy1, ey2), cross_im(ey1, hy2, hy1, ey2),
                         dr, di, mag2, sat);
      e.z_yy = impedance(cross_re(ey2, hx1, hx2, ey1), cross_im(ey2, hx1, hx2, ey1),
                         dr, di, mag2, sat);
      e.saturated = sat;
    end
    pending_q.push_back(e);
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  task check_tensor(fsti_pkg::out_item_t got);
    fsti_pkg::out_item_t e;
    if (pending_q.size() == 0) begin
      report("unexpected result", got.z_xx, 64'd0);
      return;
    end
    e = pending_q.pop_front();
    if (got.z_xx !== e.z_xx) report("z_xx", got.z_xx, e.z_xx);
    if (got.z_xy !== e.z_xy) report("z_xy", got.z_xy, e.z_xy);
    if (got.z_yx !== e.z_yx) report("z_yx", got.z_yx, e.z_yx);
    if (got.z_yy !== e.z_yy) report("z_yy", got.z_yy, e.z_yy);
    if (got.singular !== e.singular) report("singular", 64'(got.singular), 64'(e.singular));
    if (got.saturated !== e.saturated)
      report("saturated", 64'(got.saturated), 64'(e.saturated));
  endtask
endclass

module tb_field_spectra_to_impedance;
  import fsti_pkg::*;

  localparam int PIPE_LATENCY = 37;
  localparam int RANDOM_ITEMS = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_res;

  tensor_scoreboard tensors = new();
  int sender_idle_pct = 20;

  field_spectra_to_impedance DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_res(out_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Results cannot be held off, so every strobed cycle is checked at its closing edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) tensors.check_tensor(out_res);
  end

  // Presents one transaction, with an optional random gap in front of it, and keeps
  // start high until the edge that accepts it. start is lowered only when the next
  // transaction does not follow directly, so it never sees two assignments per step.
  task send_spectra(in_item_t it);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    tensors.note_spectra(it);
  endtask

  function automatic logic [31:0] rand_c16();
    logic [15:0] re, im;
    // Field extremes often, otherwise anything.
    case ($urandom_range(5))
      0: re = 16'h8000;
      1: re = 16'h7fff;
      2: re = 16'h0000;
      default: re = 16'($urandom);
    endcase
    case ($urandom_range(5))
      0: im = 16'h8000;
      1: im = 16'h7fff;
      2: im = 16'h0000;
      default: im = 16'($urandom);
    endcase
    return {re, im};
  endfunction

  // Mostly well-conditioned spectra; some singular magnetic fields, some tiny
  // determinants that drive the quotient into saturation, small values too.
  function automatic in_item_t rand_spectra();
    in_item_t it;
    int kind;
    logic [31:0] small_h;
    kind = $urandom_range(9);
    it = {rand_c16(), rand_c16(), rand_c16(), rand_c16(),
          rand_c16(), rand_c16(), rand_c16(), rand_c16()};
    case (kind)
      0: begin
        // Parallel magnetic polarizations make the determinant zero.
        it.hx_pol2 = it.hx_pol1;
        it.hy_pol2 = it.hy_pol1;
      end
      1: begin
        small_h = {16'($signed($urandom_range(0, 6)) - 16'sd3),
                   16'($signed($urandom_range(0, 6)) - 16'sd3)};
        it.hx_pol1 = small_h;
        it.hy_pol2 = {16'd1, 16'd0};
        it.hy_pol1 = '0;
      end
      2: begin
        it.hx_pol1 = {16'($signed($urandom_range(0, 40)) - 16'sd20), 16'd0};
        it.hy_pol2 = {16'($signed($urandom_range(0, 40)) - 16'sd20), 16'd0};
        it.hx_pol2 = '0;
      end
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    in_item_t it;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero everything (singular), identity magnetics, extremes, saturation.
    send_spectra('0);
    it = '0;
    it.hx_pol1 = {16'd1, 16'd0}; it.hy_pol2 = {16'd1, 16'd0};
    it.ex_pol1 = 32'h7fff_8000; it.ex_pol2 = 32'h8000_7fff;
    it.ey_pol1 = 32'h0001_ffff; it.ey_pol2 = 32'hffff_0001;
    send_spectra(it);
    it.hx_pol1 = 32'h7fff_7fff; it.hy_pol2 = 32'h8000_8000;
    send_spectra(it);
    it.hx_pol1 = 32'h8000_0000; it.hy_pol2 = 32'h8000_0000;
    it.hx_pol2 = 32'h7fff_0000; it.hy_pol1 = 32'h7fff_0000;
    send_spectra(it);
    it = {8{32'h8000_8000}};
    send_spectra(it);
    it = {8{32'h7fff_7fff}};
    send_spectra(it);
    it = {32'h7fff_7fff, 32'h8000_8000, 32'h7fff_8000, 32'h8000_7fff,
          32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000};
    send_spectra(it);
    it = {32'hffff_ffff, 32'h0001_0001, 32'h1234_5678, 32'h9abc_def0,
          32'h0003_0000, 32'h0000_0000, 32'h0000_0000, 32'h0002_0000};
    send_spectra(it);
    // Non-integer quotients exercise the rounding step.
    it = {32'h0001_0000, 32'hffff_0000, 32'h0003_0000, 32'hfffd_0000,
          32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 32'h0002_0000};
    send_spectra(it);
    it = {32'h0001_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          32'h0003_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_ffff};
    send_spectra(it);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) sender_idle_pct = 50;
      if (i == 2 * RANDOM_ITEMS / 3) sender_idle_pct = 0;
      send_spectra(rand_spectra());
    end
    start <= 1'b0;

    while (tensors.pending_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (tensors.errors == 0) $display("field_spectra_to_impedance verification clean");
    else $display("field_spectra_to_impedance verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("field_spectra_to_impedance verification failed");
    $finish;
  end
endmodule

`default_nettype wire

/* sim.f */
rtl/fsti_pkg.sv
rtl/fsti_front.sv
rtl/fsti_cell.sv
rtl/fsti_back.sv
rtl/field_spectra_to_impedance.sv
rtl/fsti_checker.sv
bench/tb_field_spectra_to_impedance.sv
